>>> rtl/cdss_pkg.sv
// Shared constants and types of the command driven stream slicer.
// No dependencies; every other file of the block refers to this package.
package cdss_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int CHANNELS_DEF   = 16;

    localparam int CHANNEL_W = 8;
    localparam int LENGTH_W  = 16;
    localparam int KIND_W    = 2;

    // item type carried on the input channel
    localparam logic ACTION_COMMAND = 1'b0;
    localparam logic ACTION_SAMPLE  = 1'b1;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_COPY     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAG_COPY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH    = 2'd3;

    // input item without the sample word
    typedef struct packed {
        logic                 action;
        logic [KIND_W-1:0]    command_kind;
        logic [CHANNEL_W-1:0] channel;
        logic [LENGTH_W-1:0]  command_length;
        logic                 sample_burst;
    } t_item;

    // result flags handed from the decision logic to the result register
    typedef struct packed {
        logic accepted;
        logic out_valid;
        logic out_start_tag;
    } t_flags;

endpackage

>>> rtl/cdss_if.sv
// Valid/ready channel interfaces of the command driven stream slicer.
// Depends on cdss_pkg for field widths and defaults.
interface cdss_in_if #(
    parameter int DATA_WIDTH = cdss_pkg::DATA_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [cdss_pkg::KIND_W-1:0]    command_kind;
    logic [cdss_pkg::CHANNEL_W-1:0] channel;
    logic [cdss_pkg::LENGTH_W-1:0]  command_length;
    logic [DATA_WIDTH-1:0]          sample_data;
    logic                           sample_burst;

    modport source (
        output valid, action, command_kind, channel, command_length,
               sample_data, sample_burst,
        input  ready
    );
    modport sink (
        input  valid, action, command_kind, channel, command_length,
               sample_data, sample_burst,
        output ready
    );
endinterface

interface cdss_out_if #(
    parameter int DATA_WIDTH = cdss_pkg::DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic                  out_valid;
    logic [DATA_WIDTH-1:0] out_data;
    logic                  out_start_tag;

    modport source (
        output valid, accepted, out_valid, out_data, out_start_tag,
        input  ready
    );
    modport sink (
        input  valid, accepted, out_valid, out_data, out_start_tag,
        output ready
    );
endinterface

>>> rtl/command_driven_stream_slicer.sv
// Command driven stream slicer, top level: input register, decision core
// and result register. Depends on cdss_pkg, cdss_if and cdss_core.
//
// Usage:
//   i_item carries commands (action = 0) and samples (action = 1) on one
//   valid/ready channel. Every accepted item yields exactly one result on
//   o_result: accepted = 0 tells the sender to retry that item later
//   (a command while busy, a sample while idle, a sample from another
//   channel, or the tagged sample that ends a flush). A forwarded sample
//   shows out_valid = 1, with out_start_tag set only by a tag-copy.
//   An item taken on i_item passes the input register and then the result
//   register. Throughput: one item per clock unless the receiver stalls;
//   the mode state updates as the item leaves the input register, so the
//   next item sees it at once. Reset (synchronous, active low) returns the
//   mode to idle and empties both registers. When the receiver stalls, the
//   result register holds its item, the input register fills, and
//   i_item.ready drops until the result is taken.
module command_driven_stream_slicer #(
    parameter int DATA_WIDTH = cdss_pkg::DATA_WIDTH_DEF,
    parameter int CHANNELS   = cdss_pkg::CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cdss_in_if.sink           i_item,
    cdss_out_if.source        o_result
);

    // input register
    logic                  r_in_valid;
    cdss_pkg::t_item       r_in_item;
    logic [DATA_WIDTH-1:0] r_in_data;

    // result register
    logic                  r_out_valid;
    cdss_pkg::t_flags      r_out_flags;
    logic [DATA_WIDTH-1:0] r_out_data;

    cdss_pkg::t_flags      flags;
    logic                  advance;
    logic                  take;

    // move the held item into the result register when it has room
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign take         = i_item.valid && i_item.ready;

    cdss_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in_item),
        .o_flags (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_item.action         <= i_item.action;
            r_in_item.command_kind   <= i_item.command_kind;
            r_in_item.channel        <= i_item.channel;
            r_in_item.command_length <= i_item.command_length;
            r_in_item.sample_burst   <= i_item.sample_burst;
            r_in_data                <= i_item.sample_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // zero the data word of a result that forwards nothing
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_flags <= flags;
            r_out_data  <= flags.out_valid ? r_in_data : '0;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.accepted      = r_out_flags.accepted;
    assign o_result.out_valid     = r_out_flags.out_valid;
    assign o_result.out_data      = r_out_data;
    assign o_result.out_start_tag = r_out_flags.out_start_tag;

endmodule

>>> rtl/cdss_core.sv
// Mode state and per-item decision logic of the stream slicer.
// Depends on cdss_pkg for the item and flag types and the command codes.
module cdss_core #(
    parameter int CHANNELS = cdss_pkg::CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  cdss_pkg::t_item i_item,
    output cdss_pkg::t_flags o_flags
);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_COPY   = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_TAG    = 3'd3;
    localparam logic [2:0] MODE_FLUSH  = 3'd4;

    logic [2:0]                     r_mode, n_mode;
    logic [cdss_pkg::CHANNEL_W-1:0] r_sel, n_sel;
    logic [cdss_pkg::LENGTH_W-1:0]  r_rem, n_rem;
    logic [cdss_pkg::LENGTH_W-1:0]  rem_dec;
    logic                           chan_ok;
    logic                           len_nz;

    assign rem_dec = r_rem - cdss_pkg::LENGTH_W'(1);
    assign chan_ok = ({1'b0, i_item.channel} < (cdss_pkg::CHANNEL_W + 1)'(CHANNELS));
    assign len_nz  = (i_item.command_length != '0);

    always_comb begin
        n_mode  = r_mode;
        n_sel   = r_sel;
        n_rem   = r_rem;
        o_flags = '0;
        if (i_item.action == cdss_pkg::ACTION_COMMAND) begin
            if (r_mode == MODE_IDLE) begin
                o_flags.accepted = 1'b1;
                if (chan_ok) begin
                    n_sel = i_item.channel;
                    unique case (i_item.command_kind)
                        cdss_pkg::KIND_COPY: begin
                            if (len_nz) begin
                                n_mode = MODE_COPY;
                                n_rem  = i_item.command_length;
                            end
                        end
                        cdss_pkg::KIND_DELETE: begin
                            if (len_nz) begin
                                n_mode = MODE_DELETE;
                                n_rem  = i_item.command_length;
                            end
                        end
                        cdss_pkg::KIND_TAG_COPY: n_mode = MODE_TAG;
                        cdss_pkg::KIND_FLUSH:    n_mode = MODE_FLUSH;
                    endcase
                end
            end
        end else if (r_mode != MODE_IDLE && i_item.channel == r_sel) begin
            unique case (r_mode) inside
                MODE_COPY, MODE_DELETE: begin
                    o_flags.accepted  = 1'b1;
                    o_flags.out_valid = (r_mode == MODE_COPY);
                    n_rem             = rem_dec;
                    if (rem_dec == '0) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_TAG: begin
                    o_flags.accepted      = 1'b1;
                    o_flags.out_valid     = 1'b1;
                    o_flags.out_start_tag = 1'b1;
                    n_mode                = MODE_IDLE;
                end
                default: begin
                    // flush: stop at a tagged sample and leave it unconsumed
                    if (i_item.sample_burst) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        o_flags.accepted = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_sel  <= '0;
            r_rem  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_sel  <= n_sel;
            r_rem  <= n_rem;
        end
    end

endmodule

>>> rtl/cdss_checker.sv
// Port-level checks on the result channel of the stream slicer, bound to
// the top level. Depends on cdss_pkg and command_driven_stream_slicer.
module cdss_checker #(
    parameter int DATA_WIDTH = cdss_pkg::DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input logic                  i_accepted,
    input logic                  i_out_valid,
    input logic [DATA_WIDTH-1:0] i_out_data,
    input logic                  i_out_start_tag
);

    // a forwarded sample always consumes its item
    a_fwd_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_out_valid) |-> i_accepted)
        else $error("forwarded sample not marked accepted");

    // nothing forwarded means a zero data word and no start tag
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_out_valid) |-> (i_out_data == '0 && !i_out_start_tag))
        else $error("payload not cleared on a result without a sample");

    // a start tag only rides on a forwarded sample
    a_tag_forwarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_out_start_tag) |-> i_out_valid)
        else $error("start tag without a forwarded sample");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_accepted) && $stable(i_out_valid)
             && $stable(i_out_data) && $stable(i_out_start_tag)))
        else $error("result changed while stalled");

endmodule

bind command_driven_stream_slicer cdss_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cdss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_result.valid),
    .i_res_ready     (o_result.ready),
    .i_accepted      (o_result.accepted),
    .i_out_valid     (o_result.out_valid),
    .i_out_data      (o_result.out_data),
    .i_out_start_tag (o_result.out_start_tag)
);
